// File: hdl/tlcc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and defaults of the two-level cache controller.
// Set counts and the line size are powers of two; way counts are free.
package tlcc_pkg;

  localparam int L1_SETS_DEF    = 128;
  localparam int L1_WAYS_DEF    = 8;
  localparam int L2_SETS_DEF    = 4096;
  localparam int L2_WAYS_DEF    = 16;
  localparam int LINE_BYTES_DEF = 64;
  localparam int BURST_BYTES    = 8;

  // Galois feedback taps of the victim generator.
  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  // Shift of the reciprocal used to reduce a random value modulo the way count.
  localparam int MOD_SHIFT = 21;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_FILL  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    KIND_DONE     = 2'd0,
    KIND_BURST_WR = 2'd1,
    KIND_BURST_RD = 2'd2,
    KIND_WR_THRU  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEG,
    ST_EVAL,
    ST_PUT_LO,
    ST_PUT_HI,
    ST_WB_RD,
    ST_WB,
    ST_REQ,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_DONE
  } state_t;

  // One step of the victim generator.
  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] s;
    s = v >> 1;
    return v[0] ? (s ^ LFSR_TAPS) : s;
  endfunction

endpackage

// File: hdl/tlcc_req_if.sv
`timescale 1ns / 1ps
// Request channel: accesses and fill beats.
interface tlcc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] addr;
  logic [2:0]  len;
  logic [31:0] wdata;
  logic [63:0] fill_data;

  modport source (output valid, func, addr, len, wdata, fill_data, input ready);
  modport sink (input valid, func, addr, len, wdata, fill_data, output ready);
endinterface

// File: hdl/tlcc_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: completions and memory traffic.
interface tlcc_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] mem_addr;
  logic [63:0] mem_data;
  logic [7:0]  byte_mask;
  logic [31:0] rdata;
  logic        last;

  modport source (output valid, kind, mem_addr, mem_data, byte_mask, rdata, last,
                  input ready);
  modport sink (input valid, kind, mem_addr, mem_data, byte_mask, rdata, last,
                output ready);
endinterface

// File: hdl/tlcc_cfg_if.sv
`timescale 1ns / 1ps
// Configuration channel: the victim generator seed.
interface tlcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] replace_seed;

  modport source (output valid, replace_seed, input ready);
  modport sink (input valid, replace_seed, output ready);
endinterface

// File: hdl/tlcc_tag_mem.sv
`timescale 1ns / 1ps
// Tag memory: one row per set, one lane per way, lane write enables,
// whole-row registered read.
module tlcc_tag_mem #(
  parameter int ROWS  = 2,
  parameter int LANES = 1,
  parameter int EW    = 1,
  localparam int AW   = $clog2(ROWS)
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [LANES-1:0][EW-1:0]  rd_row,
  input  logic [LANES-1:0]          wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [EW-1:0]             wr_data
);

  logic [LANES-1:0][EW-1:0] mem [ROWS];

  // Lane writes.
  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (wr_en[l]) begin
        mem[wr_addr][l] <= wr_data;
      end
    end
  end

  // Registered row read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/two_level_cache_controller.sv
`timescale 1ns / 1ps
// One item at a time. A read hit returns its result from the tag lookup; a write hit
// puts its bytes into L2, with a write-through result first on an L1 hit and a second
// segment for a write that crosses the line end. An L2 miss sends write-back bursts for
// a dirty victim and then the burst read requests, and completes after the final fill beat.
// After reset a clearing pass over max(L1_SETS, L2_SETS) tag rows runs with the
// request channel not ready; the seed port is always ready.
module two_level_cache_controller #(
  parameter int L1_SETS    = tlcc_pkg::L1_SETS_DEF,
  parameter int L1_WAYS    = tlcc_pkg::L1_WAYS_DEF,
  parameter int L2_SETS    = tlcc_pkg::L2_SETS_DEF,
  parameter int L2_WAYS    = tlcc_pkg::L2_WAYS_DEF,
  parameter int LINE_BYTES = tlcc_pkg::LINE_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  tlcc_req_if.sink   req,
  tlcc_rsp_if.source rsp,
  tlcc_cfg_if.sink   cfg
);
  import tlcc_pkg::*;

  localparam int OFF_W    = $clog2(LINE_BYTES);
  localparam int BEATS    = LINE_BYTES / BURST_BYTES;
  localparam int BEAT_W   = (BEATS > 1) ? $clog2(BEATS) : 1;
  localparam int L1_IDX_W = $clog2(L1_SETS);
  localparam int L2_IDX_W = $clog2(L2_SETS);
  localparam int L1_TW    = 32 - OFF_W - L1_IDX_W;
  localparam int L2_TW    = 32 - OFF_W - L2_IDX_W;
  localparam int L1_EW    = L1_TW + 1;
  localparam int L2_EW    = L2_TW + 2;
  localparam int L1WW     = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
  localparam int L2WW     = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
  localparam int L1L_W    = $clog2(L1_SETS * L1_WAYS);
  localparam int L2L_W    = $clog2(L2_SETS * L2_WAYS);
  localparam int DM_DEPTH = L2_SETS * L2_WAYS * BEATS;
  localparam int DM_W     = $clog2(DM_DEPTH);
  localparam int MAX_SETS = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
  localparam int CLR_W    = $clog2(MAX_SETS);
  localparam longint M1   = (longint'(1) << MOD_SHIFT) / L1_WAYS + 1;
  localparam longint M2   = (longint'(1) << MOD_SHIFT) / L2_WAYS + 1;

  // Control registers.
  state_t               state, state_next;
  op_t                  op;
  logic                 seg;
  logic                 acc_wr;
  logic                 wt_done;
  logic [CLR_W-1:0]     clr_cnt;
  logic [BEAT_W:0]      fill_cnt;
  logic [BEAT_W-1:0]    beat;
  logic [15:0]          lfsr;

  // Pending access and miss bookkeeping.
  logic [31:0]          p_addr;
  logic [31:0]          p_data;
  logic [2:0]           len_q;
  logic [L2L_W-1:0]     miss_line;
  logic [L2WW-1:0]      miss_way;
  logic [L2_TW-1:0]     vic_tag;
  logic [L2L_W-1:0]     put_line;

  // Random way pipeline.
  logic [15:0]          lfsr_nx;
  logic [15:0]          rnd_nx, rnd_q1, rnd_q2;
  logic [15:0]          rnd_r1, rnd_r2;
  logic [L1WW-1:0]      way1;
  logic [L2WW-1:0]      way2;
  logic                 lfsr_adv;

  // Result register.
  logic                 o_valid;
  kind_t                o_kind;
  logic [31:0]          o_addr;
  logic [63:0]          o_data;
  logic [7:0]           o_mask;
  logic [31:0]          o_rdata;
  logic                 o_last;
  logic                 out_free;
  logic                 out_load;
  logic                 emit;
  kind_t                e_kind;
  logic [31:0]          e_addr;
  logic [63:0]          e_data;
  logic [7:0]           e_mask;
  logic [31:0]          e_rdata;
  logic                 e_last;

  // Memory ports.
  logic                             tag_rd;
  logic [L1_WAYS-1:0][L1_EW-1:0]    l1_q;
  logic [L2_WAYS-1:0][L2_EW-1:0]    l2_q;
  logic [L1_WAYS-1:0]               l1_wen;
  logic [L1_IDX_W-1:0]              l1_wa;
  logic [L1_EW-1:0]                 l1_wd;
  logic [L2_WAYS-1:0]               l2_wen;
  logic [L2_IDX_W-1:0]              l2_wa;
  logic [L2_EW-1:0]                 l2_wd;
  logic [7:0][7:0]                  dmem [DM_DEPTH];
  logic                             dm_we, dm_re;
  logic [DM_W-1:0]                  dm_wa, dm_ra;
  logic [7:0]                       dm_be;
  logic [63:0]                      dm_wd;
  logic [63:0]                      dm_q;

  // Segment of the current access.
  logic                 in_acc, access_ok, fill_ok, fill_last;
  logic [2:0]           len_c;
  logic [OFF_W-1:0]     p_off;
  logic [OFF_W:0]       room;
  logic [2:0]           n1;
  logic                 nseg2;
  logic [31:0]          seg_a, seg_d;
  logic [2:0]           seg_n;
  logic [L1_IDX_W-1:0]  l1_set_a;
  logic [L2_IDX_W-1:0]  l2_set_a;
  logic [L1_TW-1:0]     l1_tag_a;
  logic [L2_TW-1:0]     l2_tag_a;
  logic [15:0]          mask16;
  logic [127:0]         data128;
  logic [BEAT_W-1:0]    word0;
  logic [7:0]           nmask;
  logic [63:0]          wt_mask;

  // Lookup results.
  logic                 l1_hit, l2_hit;
  logic [L1WW-1:0]      l1_way;
  logic [L2WW-1:0]      l2_way;
  logic [L2_EW-1:0]     vic_e;
  logic                 vic_dirty;
  logic                 rd_l1, rd_fill, wr_wt, wr_hit, miss;
  logic                 beat_last, clr_last, hi_needed;
  logic [L1L_W-1:0]     l1_hit_line, l1_fill_line;
  logic [L2L_W-1:0]     l2_hit_line, l2_vic_line;
  state_t               after_put, after_miss;

  assign in_acc    = req.valid && req.ready;
  assign len_c     = (req.len > 3'd4) ? 3'd4 : req.len;
  assign access_ok = (req.func == FUNC_READ || req.func == FUNC_WRITE) && op == OP_IDLE;
  assign fill_ok   = req.func == FUNC_FILL && op != OP_IDLE &&
                     fill_cnt < (BEAT_W+1)'(BEATS);
  assign fill_last = fill_cnt == (BEAT_W+1)'(BEATS - 1);

  // Split a write at the line boundary.
  assign p_off  = p_addr[OFF_W-1:0];
  assign room   = (OFF_W+1)'(LINE_BYTES) - {1'b0, p_off};
  assign n1     = ((OFF_W+1)'(len_q) < room) ? len_q : room[2:0];
  assign nseg2  = len_q > n1;
  assign seg_a  = seg ? p_addr + 32'(n1) : p_addr;
  assign seg_n  = seg ? len_q - n1 : n1;
  assign seg_d  = seg ? (p_data >> {n1, 3'b000}) : p_data;

  assign l1_set_a = seg_a[OFF_W +: L1_IDX_W];
  assign l2_set_a = seg_a[OFF_W +: L2_IDX_W];
  assign l1_tag_a = seg_a[31 -: L1_TW];
  assign l2_tag_a = seg_a[31 -: L2_TW];

  // Byte lanes of a segment inside its line.
  assign mask16  = 16'((16'd1 << seg_n) - 16'd1) << seg_a[2:0];
  assign data128 = 128'(seg_d) << {seg_a[2:0], 3'b000};
  assign word0   = BEAT_W'((seg_a % LINE_BYTES) >> 3);
  assign nmask   = 8'((16'd1 << seg_n) - 16'd1);
  assign wt_mask = (64'd1 << {seg_n, 3'b000}) - 64'd1;
  assign hi_needed = mask16[15:8] != 8'd0;

  // Random way: quotient by reciprocal registered, remainder in the next cycle.
  assign lfsr_nx = lfsr_step(lfsr);
  always_ff @(posedge clk) begin
    rnd_nx <= lfsr_nx;
    rnd_q1 <= 16'((40'(lfsr_nx) * 40'(M1)) >> MOD_SHIFT);
    rnd_q2 <= 16'((40'(lfsr_nx) * 40'(M2)) >> MOD_SHIFT);
  end
  assign rnd_r1 = rnd_nx - 16'(rnd_q1 * 16'(L1_WAYS));
  assign rnd_r2 = rnd_nx - 16'(rnd_q2 * 16'(L2_WAYS));
  assign way1   = rnd_r1[L1WW-1:0];
  assign way2   = rnd_r2[L2WW-1:0];

  // Tag compare over the ways; the lowest way wins.
  always_comb begin
    l1_hit = 1'b0;
    l1_way = '0;
    for (int w = L1_WAYS - 1; w >= 0; w--) begin
      if (l1_q[w] == {l1_tag_a, 1'b1}) begin
        l1_hit = 1'b1;
        l1_way = L1WW'(w);
      end
    end
  end

  always_comb begin
    l2_hit = 1'b0;
    l2_way = '0;
    for (int w = L2_WAYS - 1; w >= 0; w--) begin
      if (l2_q[w][0] && l2_q[w][L2_EW-1:2] == l2_tag_a) begin
        l2_hit = 1'b1;
        l2_way = L2WW'(w);
      end
    end
  end

  assign vic_e     = l2_q[way2];
  assign vic_dirty = vic_e[1] && vic_e[0];

  assign rd_l1   = !acc_wr && l1_hit;
  assign rd_fill = !acc_wr && !l1_hit && l2_hit;
  assign wr_wt   = acc_wr && l1_hit && !wt_done;
  assign wr_hit  = acc_wr && !wr_wt && l2_hit;
  assign miss    = (!acc_wr && !l1_hit && !l2_hit) || (acc_wr && !wr_wt && !l2_hit);

  assign l1_hit_line  = L1L_W'(l1_set_a) * L1L_W'(L1_WAYS) + L1L_W'(l1_way);
  assign l1_fill_line = L1L_W'(l1_set_a) * L1L_W'(L1_WAYS) + L1L_W'(way1);
  assign l2_hit_line  = L2L_W'(l2_set_a) * L2L_W'(L2_WAYS) + L2L_W'(l2_way);
  assign l2_vic_line  = L2L_W'(l2_set_a) * L2L_W'(L2_WAYS) + L2L_W'(way2);

  assign beat_last  = beat == BEAT_W'(BEATS - 1);
  assign clr_last   = clr_cnt == CLR_W'(MAX_SETS - 1);
  assign after_put  = (!seg && nseg2) ? ST_SEG : ST_DONE;
  assign after_miss = vic_dirty ? ST_WB_RD : ST_REQ;
  assign out_free   = !o_valid || rsp.ready;
  assign out_load   = emit && out_free;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc && access_ok) begin
          if (req.func == FUNC_WRITE && len_c == 3'd0) state_next = ST_DONE;
          else state_next = ST_SEG;
        end else if (in_acc && fill_ok && fill_last) begin
          state_next = (op == OP_READ) ? ST_FILL_RD : ST_FILL_WR;
        end
      end
      ST_SEG: state_next = ST_EVAL;
      ST_EVAL: begin
        if (rd_l1 || rd_fill) begin
          if (out_free) state_next = ST_IDLE;
        end else if (wr_hit) begin
          state_next = ST_PUT_LO;
        end else if (miss) begin
          state_next = after_miss;
        end
      end
      ST_PUT_LO: state_next = hi_needed ? ST_PUT_HI : after_put;
      ST_PUT_HI: state_next = after_put;
      ST_WB_RD: state_next = ST_WB;
      ST_WB: begin
        if (out_free) state_next = beat_last ? ST_REQ : ST_WB_RD;
      end
      ST_REQ: begin
        if (out_free && beat_last) state_next = ST_IDLE;
      end
      ST_FILL_RD: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_FILL_WR: state_next = ST_PUT_LO;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory controls and result beats.
  always_comb begin
    emit     = 1'b0;
    e_kind   = KIND_DONE;
    e_addr   = '0;
    e_data   = '0;
    e_mask   = '0;
    e_rdata  = '0;
    e_last   = 1'b0;
    tag_rd   = 1'b0;
    l1_wen   = '0;
    l1_wa    = l1_set_a;
    l1_wd    = {l1_tag_a, 1'b1};
    l2_wen   = '0;
    l2_wa    = l2_set_a;
    l2_wd    = {l2_tag_a, 2'b11};
    dm_we    = 1'b0;
    dm_wa    = DM_W'(put_line) * DM_W'(BEATS) + DM_W'(word0);
    dm_be    = mask16[7:0];
    dm_wd    = data128[63:0];
    dm_re    = 1'b0;
    dm_ra    = DM_W'(miss_line) * DM_W'(BEATS) + DM_W'(beat);
    lfsr_adv = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        l1_wa = L1_IDX_W'(clr_cnt);
        l1_wd = '0;
        l2_wa = L2_IDX_W'(clr_cnt);
        l2_wd = '0;
        if ((CLR_W+1)'(clr_cnt) < (CLR_W+1)'(L1_SETS)) l1_wen = '1;
        if ((CLR_W+1)'(clr_cnt) < (CLR_W+1)'(L2_SETS)) l2_wen = '1;
      end
      ST_IDLE: begin
        if (in_acc && fill_ok) begin
          dm_we = 1'b1;
          dm_wa = DM_W'(miss_line) * DM_W'(BEATS) + DM_W'(fill_cnt[BEAT_W-1:0]);
          dm_be = 8'hFF;
          dm_wd = req.fill_data;
        end
      end
      ST_SEG: tag_rd = 1'b1;
      ST_EVAL: begin
        if (rd_l1) begin
          emit    = 1'b1;
          e_rdata = 32'(l1_hit_line);
          e_last  = 1'b1;
        end else if (rd_fill) begin
          emit    = 1'b1;
          e_rdata = 32'(l1_fill_line);
          e_last  = 1'b1;
          if (out_free) begin
            l1_wen   = L1_WAYS'(1) << way1;
            lfsr_adv = 1'b1;
          end
        end else if (wr_wt) begin
          emit   = 1'b1;
          e_kind = KIND_WR_THRU;
          e_addr = seg_a;
          e_data = 64'(seg_d) & wt_mask;
          e_mask = nmask;
        end else if (wr_hit) begin
          l2_wen = L2_WAYS'(1) << l2_way;
        end else if (miss) begin
          lfsr_adv = 1'b1;
        end
      end
      ST_PUT_LO: dm_we = 1'b1;
      ST_PUT_HI: begin
        dm_we = 1'b1;
        dm_wa = DM_W'(put_line) * DM_W'(BEATS) + DM_W'(word0) + DM_W'(1);
        dm_be = mask16[15:8];
        dm_wd = data128[127:64];
      end
      ST_WB_RD: dm_re = 1'b1;
      ST_WB: begin
        emit   = 1'b1;
        e_kind = KIND_BURST_WR;
        e_addr = {vic_tag, l2_set_a, OFF_W'(0)} + (32'(beat) << 3);
        e_data = dm_q;
        e_mask = 8'hFF;
      end
      ST_REQ: begin
        emit   = 1'b1;
        e_kind = KIND_BURST_RD;
        e_addr = {seg_a[31:OFF_W], OFF_W'(0)} + (32'(beat) << 3);
        e_last = beat_last;
      end
      ST_FILL_RD: begin
        emit    = 1'b1;
        e_rdata = 32'(l1_fill_line);
        e_last  = 1'b1;
        l2_wd   = {l2_tag_a, 2'b01};
        if (out_free) begin
          l1_wen   = L1_WAYS'(1) << way1;
          l2_wen   = L2_WAYS'(1) << miss_way;
          lfsr_adv = 1'b1;
        end
      end
      ST_FILL_WR: l2_wen = L2_WAYS'(1) << miss_way;
      ST_DONE: begin
        emit   = 1'b1;
        e_last = 1'b1;
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      op       <= OP_IDLE;
      seg      <= 1'b0;
      acc_wr   <= 1'b0;
      wt_done  <= 1'b0;
      clr_cnt  <= '0;
      fill_cnt <= '0;
      beat     <= '0;
      lfsr     <= 16'd1;
      o_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + CLR_W'(1);

      if (cfg.valid && cfg.ready) begin
        lfsr <= (cfg.replace_seed == 16'd0) ? 16'd1 : cfg.replace_seed;
      end else if (lfsr_adv) begin
        lfsr <= lfsr_nx;
      end

      if (state == ST_IDLE && in_acc && access_ok) begin
        seg    <= 1'b0;
        acc_wr <= req.func == FUNC_WRITE;
      end
      if (state == ST_IDLE && in_acc && fill_ok) fill_cnt <= fill_cnt + (BEAT_W+1)'(1);
      if ((state == ST_PUT_LO && !hi_needed) || state == ST_PUT_HI) begin
        if (!seg && nseg2) seg <= 1'b1;
      end

      if (state == ST_SEG) wt_done <= 1'b0;
      if (state == ST_EVAL && wr_wt && out_free) wt_done <= 1'b1;

      if (state == ST_EVAL && miss) begin
        op       <= acc_wr ? OP_WRITE : OP_READ;
        fill_cnt <= '0;
        beat     <= '0;
      end
      if ((state == ST_WB || state == ST_REQ) && out_free) begin
        beat <= beat_last ? '0 : beat + BEAT_W'(1);
      end
      if ((state == ST_FILL_RD || state == ST_DONE) && out_free) op <= OP_IDLE;

      if (out_load) o_valid <= 1'b1;
      else if (rsp.ready) o_valid <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_acc && access_ok) begin
      p_addr <= req.addr;
      p_data <= req.wdata;
      len_q  <= (req.func == FUNC_WRITE) ? len_c : 3'd0;
    end
    if (state == ST_EVAL && miss) begin
      miss_line <= l2_vic_line;
      miss_way  <= way2;
      vic_tag   <= vic_e[L2_EW-1:2];
    end
    if (state == ST_EVAL && wr_hit) put_line <= l2_hit_line;
    if (state == ST_FILL_WR) put_line <= miss_line;
    if (out_load) begin
      o_kind  <= e_kind;
      o_addr  <= e_addr;
      o_data  <= e_data;
      o_mask  <= e_mask;
      o_rdata <= e_rdata;
      o_last  <= e_last;
    end
  end

  // Line data of L2, byte-enabled writes and a registered read.
  always_ff @(posedge clk) begin
    if (dm_we) begin
      for (int b = 0; b < 8; b++) begin
        if (dm_be[b]) dmem[dm_wa][b] <= dm_wd[b*8 +: 8];
      end
    end
    if (dm_re) dm_q <= dmem[dm_ra];
  end

  tlcc_tag_mem #(
    .ROWS  (L1_SETS),
    .LANES (L1_WAYS),
    .EW    (L1_EW)
  ) u_l1_tags (
    .clk     (clk),
    .rd_en   (tag_rd),
    .rd_addr (l1_set_a),
    .rd_row  (l1_q),
    .wr_en   (l1_wen),
    .wr_addr (l1_wa),
    .wr_data (l1_wd)
  );

  tlcc_tag_mem #(
    .ROWS  (L2_SETS),
    .LANES (L2_WAYS),
    .EW    (L2_EW)
  ) u_l2_tags (
    .clk     (clk),
    .rd_en   (tag_rd),
    .rd_addr (l2_set_a),
    .rd_row  (l2_q),
    .wr_en   (l2_wen),
    .wr_addr (l2_wa),
    .wr_data (l2_wd)
  );

  // Channel ports.
  assign req.ready     = state == ST_IDLE;
  assign cfg.ready     = 1'b1;
  assign rsp.valid     = o_valid;
  assign rsp.kind      = o_kind;
  assign rsp.mem_addr  = o_addr;
  assign rsp.mem_data  = o_data;
  assign rsp.byte_mask = o_mask;
  assign rsp.rdata     = o_rdata;
  assign rsp.last      = o_last;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import tlcc_pkg::*;

  localparam int L1_SETS = 128;
  localparam int L1_WAYS = 8;
  localparam int L2_SETS = 4096;
  localparam int L2_WAYS = 16;
  localparam int LINE = 64;
  localparam int BEATS = LINE / BURST_BYTES;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 30;
  localparam int RANDOM_ITEMS = 60;

  typedef struct {
    kind_t       kind;
    logic [31:0] mem_addr;
    logic [63:0] mem_data;
    logic [7:0]  byte_mask;
    logic [31:0] rdata;
    logic        last;
  } mem_beat_t;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] addr;
    logic [2:0]  len;
    logic [31:0] wdata;
    logic [63:0] fill;
    bit          typed;
    kind_t       kind;
    logic [31:0] mem_addr;
    logic [31:0] rdata;
  } access_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors = 0;
  int   quiet_cycles = 0;
  bit   no_idle = 1'b0;

  tlcc_req_if req();
  tlcc_rsp_if rsp();
  tlcc_cfg_if cfg();

  two_level_cache_controller dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always #5 clk = ~clk;

  // Shadow state of both cache levels and of the pending miss.
  logic [31:0] l1_tags [L1_SETS*L1_WAYS];
  logic [31:0] l2_tags [L2_SETS*L2_WAYS];
  logic [7:0]  l2_bytes [int];
  logic [15:0] victim_state;
  logic [31:0] miss_addr;
  logic [31:0] miss_wdata;
  op_t         miss_op;
  int          miss_seg;
  int          miss_len;
  int          beats_in;
  int          victim_slot;
  mem_beat_t   due_beats[$];

  function automatic int next_victim();
    logic [15:0] v;
    v = victim_state >> 1;
    if (victim_state[0]) v = v ^ 16'hB400;
    victim_state = v;
    return int'(v);
  endfunction

  function automatic void push_beat(kind_t k, logic [31:0] a, logic [63:0] d,
                                    logic [7:0] m, logic [31:0] r);
    mem_beat_t b;
    b.kind = k;
    b.mem_addr = a;
    b.mem_data = d;
    b.byte_mask = m;
    b.rdata = r;
    b.last = 1'b0;
    due_beats.push_back(b);
  endfunction

  function automatic int l1_lookup(logic [31:0] a);
    int base;
    base = int'(a[12:6]) * L1_WAYS;
    for (int w = 0; w < L1_WAYS; w++) begin
      if (l1_tags[base + w] == {a[31:13], 1'b1}) return base + w;
    end
    return -1;
  endfunction

  function automatic int l2_lookup(logic [31:0] a);
    int base;
    base = int'(a[17:6]) * L2_WAYS;
    for (int w = 0; w < L2_WAYS; w++) begin
      if (l2_tags[base + w][0] && (l2_tags[base + w] >> 2) == a[31:18]) return base + w;
    end
    return -1;
  endfunction

  function automatic int l1_allocate(logic [31:0] a);
    int slot;
    slot = int'(a[12:6]) * L1_WAYS + next_victim() % L1_WAYS;
    l1_tags[slot] = {a[31:13], 1'b1};
    return slot;
  endfunction

  function automatic logic [7:0] l2_byte(int idx);
    return l2_bytes.exists(idx) ? l2_bytes[idx] : 8'h00;
  endfunction

  // Victim choice, dirty write-back bursts, then the burst read requests.
  function automatic void start_l2_miss(logic [31:0] a);
    int slot;
    logic [31:0] old_base;
    logic [63:0] v;
    slot = int'(a[17:6]) * L2_WAYS + next_victim() % L2_WAYS;
    if (l2_tags[slot][1:0] == 2'b11) begin
      old_base = {l2_tags[slot][15:2], a[17:6], 6'd0};
      for (int w = 0; w < BEATS; w++) begin
        for (int k = 0; k < 8; k++) v[8*k +: 8] = l2_byte(slot*LINE + w*8 + k);
        push_beat(KIND_BURST_WR, old_base + w*8, v, 8'hFF, 32'd0);
      end
    end
    for (int w = 0; w < BEATS; w++) push_beat(KIND_BURST_RD, {a[31:6], 6'd0} + w*8, 64'd0, 8'd0, 32'd0);
    victim_slot = slot;
    beats_in = 0;
  endfunction

  function automatic void l2_store(int slot, logic [31:0] a, int n, logic [31:0] d);
    int off;
    off = int'(a[5:0]);
    for (int k = 0; k < n && off + k < LINE; k++) l2_bytes[slot*LINE + off + k] = d[8*k +: 8];
    l2_tags[slot][1] = 1'b1;
  endfunction

  // One line-local piece of a write; returns 0 when it waits on a fill.
  function automatic bit write_piece(logic [31:0] a, int n, logic [31:0] d);
    int s1, s2;
    logic [63:0] keep;
    s1 = l1_lookup(a);
    if (s1 >= 0) begin
      keep = (64'd1 << (8*n)) - 64'd1;
      push_beat(KIND_WR_THRU, a, {32'd0, d} & keep, 8'((1 << n) - 1), 32'd0);
    end
    s2 = l2_lookup(a);
    if (s2 >= 0) begin
      l2_store(s2, a, n, d);
      return 1'b1;
    end
    start_l2_miss(a);
    return 1'b0;
  endfunction

  function automatic void run_write(int first, bit resumed);
    logic [31:0] pa [2];
    logic [31:0] pd [2];
    int pn [2];
    int off, n1, count;
    off = int'(miss_addr[5:0]);
    n1 = (miss_len < LINE - off) ? miss_len : LINE - off;
    count = 0;
    if (miss_len > 0) begin
      pa[0] = miss_addr;
      pn[0] = n1;
      pd[0] = miss_wdata;
      count = 1;
      if (miss_len > n1) begin
        pa[1] = miss_addr + n1;
        pn[1] = miss_len - n1;
        pd[1] = miss_wdata >> (8*n1);
        count = 2;
      end
    end
    for (int s = first; s < count; s++) begin
      if (resumed && s == first) begin
        l2_tags[victim_slot] = {pa[s][31:18], 2'b01};
        l2_store(victim_slot, pa[s], pn[s], pd[s]);
      end else if (!write_piece(pa[s], pn[s], pd[s])) begin
        miss_op = OP_WRITE;
        miss_seg = s;
        return;
      end
    end
    miss_op = OP_IDLE;
    push_beat(KIND_DONE, 32'd0, 64'd0, 8'd0, 32'd0);
  endfunction

  function automatic void predict_access(logic [1:0] f, logic [31:0] a, logic [2:0] l,
                                         logic [31:0] w, logic [63:0] fd);
    int prior_count, s1, s2;
    prior_count = due_beats.size();
    if (f == FUNC_FILL) begin
      if (miss_op != OP_IDLE && beats_in < BEATS) begin
        for (int k = 0; k < 8; k++) l2_bytes[victim_slot*LINE + beats_in*8 + k] = fd[8*k +: 8];
        beats_in++;
        if (beats_in == BEATS) begin
          if (miss_op == OP_READ) begin
            l2_tags[victim_slot] = {miss_addr[31:18], 2'b01};
            miss_op = OP_IDLE;
            push_beat(KIND_DONE, 32'd0, 64'd0, 8'd0, 32'(l1_allocate(miss_addr)));
          end else begin
            run_write(miss_seg, 1'b1);
          end
        end
      end
    end else if (f < 2 && miss_op == OP_IDLE) begin
      miss_addr = a;
      if (f == FUNC_READ) begin
        s1 = l1_lookup(a);
        if (s1 >= 0) begin
          push_beat(KIND_DONE, 32'd0, 64'd0, 8'd0, 32'(s1));
        end else begin
          s2 = l2_lookup(a);
          if (s2 >= 0) begin
            push_beat(KIND_DONE, 32'd0, 64'd0, 8'd0, 32'(l1_allocate(a)));
          end else begin
            start_l2_miss(a);
            miss_op = OP_READ;
          end
        end
      end else begin
        miss_wdata = w;
        miss_len = (l > 4) ? 4 : int'(l);
        run_write(0, 1'b0);
      end
    end
    if (due_beats.size() > prior_count) due_beats[$].last = 1'b1;
  endfunction

  // Request sender: random gap, then hold the beat until it is taken.
  task automatic send_access(input logic [1:0] f, input logic [31:0] a, input logic [2:0] l,
                             input logic [31:0] w, input logic [63:0] fd, output int first);
    int gap;
    gap = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func <= f;
    req.addr <= a;
    req.len <= l;
    req.wdata <= w;
    req.fill_data <= fd;
    do @(posedge clk); while (!req.ready);
    first = due_beats.size();
    predict_access(f, a, l, w, fd);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [15:0] seed);
    cfg.valid <= 1'b1;
    cfg.replace_seed <= seed;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    victim_state = (seed == 16'd0) ? 16'd1 : seed;
  endtask

  function automatic logic [31:0] pick_addr();
    logic [11:0] set;
    logic [5:0]  off;
    if ($urandom_range(0, 7) == 0) return $urandom;
    case ($urandom_range(0, 3))
      0: set = 12'd0;
      1: set = 12'd1;
      2: set = 12'hFFF;
      default: set = 12'($urandom_range(0, 3));
    endcase
    off = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(60, 63)) : 6'($urandom);
    return {14'($urandom_range(0, 19)), set, off};
  endfunction

  // Random traffic; mostly well-formed accesses followed by their fill beats.
  task automatic random_phase(input int items);
    int sent, first;
    logic [2:0] l;
    sent = 0;
    while (sent < items || miss_op != OP_IDLE) begin
      if (miss_op != OP_IDLE) begin
        case ($urandom_range(0, 15))
          13: send_access(FUNC_READ, pick_addr(), 3'd1, $urandom, 64'd0, first);
          14: send_access(FUNC_UNUSED, $urandom, 3'($urandom), $urandom, 64'd0, first);
          default: begin
            send_access(FUNC_FILL, $urandom, 3'($urandom), $urandom, {$urandom, $urandom}, first);
            sent++;
          end
        endcase
      end else begin
        case ($urandom_range(0, 19))
          0: send_access(FUNC_FILL, $urandom, 3'd0, $urandom, {$urandom, $urandom}, first);
          1: send_access(FUNC_UNUSED, $urandom, 3'($urandom), $urandom, 64'd0, first);
          default: begin
            l = ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
            send_access(($urandom_range(0, 1) == 0) ? FUNC_READ : FUNC_WRITE, pick_addr(), l,
                        $urandom, 64'd0, first);
            sent++;
          end
        endcase
      end
    end
  endtask

  task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", field, want, got);
      errors++;
    end
  endtask

  // Result receiver: random stall, then compare each beat with the oldest one due.
  initial begin
    int stall;
    mem_beat_t want;
    rsp.ready <= 1'b0;
    forever begin
      stall = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      if (due_beats.size() == 0) begin
        $error("unexpected result beat: kind %h addr %h", rsp.kind, rsp.mem_addr);
        errors++;
      end else begin
        want = due_beats.pop_front();
        report("kind", 64'(want.kind), 64'(rsp.kind));
        report("mem_addr", 64'(want.mem_addr), 64'(rsp.mem_addr));
        report("mem_data", want.mem_data, rsp.mem_data);
        report("byte_mask", 64'(want.byte_mask), 64'(rsp.byte_mask));
        report("rdata", 64'(want.rdata), 64'(rsp.rdata));
        report("last", 64'(want.last), 64'(rsp.last));
      end
    end
  end

  // Watchdog on cycles with no beat moving on any channel.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    access_row_t rows[$];
    access_row_t r;
    int first;
    req.valid <= 1'b0;
    req.func <= FUNC_READ;
    req.addr <= '0;
    req.len <= '0;
    req.wdata <= '0;
    req.fill_data <= '0;
    cfg.valid <= 1'b0;
    cfg.replace_seed <= '0;
    foreach (l1_tags[i]) l1_tags[i] = '0;
    foreach (l2_tags[i]) l2_tags[i] = '0;
    victim_state = 16'd1;
    miss_op = OP_IDLE;
    miss_addr = '0;
    miss_wdata = '0;
    miss_seg = 0;
    miss_len = 0;
    beats_in = 0;
    victim_slot = 0;

    // Directed rows: cold miss and its fill, hits, a split write, ignored items.
    rows.push_back('{FUNC_READ, 32'h0, 3'd1, 32'h0, 64'h0, 1, KIND_BURST_RD, 32'h0, 32'h0});
    for (int i = 0; i < BEATS; i++) begin
      r = '{FUNC_FILL, 32'h0, 3'd0, 32'h0, (i % 2) ? '1 : 64'h0, 0, KIND_DONE, 32'h0, 32'h0};
      if (i == BEATS - 1) r.typed = 1;
      rows.push_back(r);
    end
    rows.push_back('{FUNC_READ, 32'h4, 3'd4, 32'h0, 64'h0, 1, KIND_DONE, 32'h0, 32'h0});
    rows.push_back('{FUNC_WRITE, 32'h3E, 3'd4, '1, 64'h0, 1, KIND_WR_THRU, 32'h3E, 32'h0});
    for (int i = 0; i < BEATS; i++)
      rows.push_back('{FUNC_FILL, '1, 3'd7, '1, (i % 2) ? 64'h0 : '1, 0, KIND_DONE, 0, 0});
    rows.push_back('{FUNC_FILL, 32'h0, 3'd0, 32'h0, '1, 0, KIND_DONE, 32'h0, 32'h0});
    rows.push_back('{FUNC_UNUSED, '1, 3'd7, '1, '1, 0, KIND_DONE, 32'h0, 32'h0});
    rows.push_back('{FUNC_WRITE, 32'h100, 3'd0, '1, 64'h0, 1, KIND_DONE, 32'h0, 32'h0});
    rows.push_back('{FUNC_READ, '1, 3'd0, 32'h0, 64'h0, 1, KIND_BURST_RD, 32'hFFFFFFC0, 0});
    rows.push_back('{FUNC_WRITE, 32'h10, 3'd7, 32'h12345678, 64'h0, 0, KIND_DONE, 0, 0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      send_access(rows[i].func, rows[i].addr, rows[i].len, rows[i].wdata, rows[i].fill, first);
      if (rows[i].typed) begin
        due_beats[first].kind = rows[i].kind;
        due_beats[first].mem_addr = rows[i].mem_addr;
        due_beats[first].rdata = rows[i].rdata;
      end
    end
    random_phase(4);
    drain();

    // Seed sweep: zero, all ones with no idling, a random seed, then 16'h0001.
    write_seed(16'h0000);
    random_phase(RANDOM_ITEMS);
    drain();
    write_seed(16'hFFFF);
    no_idle = 1'b1;
    random_phase(RANDOM_ITEMS / 2);
    drain();
    no_idle = 1'b0;
    write_seed(16'($urandom));
    random_phase(RANDOM_ITEMS);
    drain();
    write_seed(16'h0001);
    random_phase(RANDOM_ITEMS / 2);
    drain();

    if (errors == 0 && due_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/tlcc_pkg.sv
hdl/tlcc_req_if.sv
hdl/tlcc_rsp_if.sv
hdl/tlcc_cfg_if.sv
hdl/tlcc_tag_mem.sv
hdl/two_level_cache_controller.sv
bench/testbench.sv
